### rtl/core/zshd_pkg.sv
// ----------------------------------------------------------------------------
// Zone schedule heating decision package
// Shared types, widths and register codes for the heating decision unit.
// ----------------------------------------------------------------------------
package zshd_pkg;

	localparam int NUM_PROGRAMS_DEF  = 8;
	localparam int STEPS_PER_DAY_DEF = 6;

	localparam int NUM_ZONES    = 3;
	localparam int ZONE_W       = 2;
	localparam logic [ZONE_W-1:0] LAST_ZONE = ZONE_W'(NUM_ZONES - 1);

	localparam int ADDR_WIDE_W  = 8;
	localparam int NOW_W        = 18;
	localparam int MONTH_WEIGHT = 10000;
	localparam int DAY_WEIGHT   = 100;
	localparam int SETPOINT_SCALE = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ZONE_ACTIVE_MASK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE0_PROGRAM    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE1_PROGRAM    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE2_PROGRAM    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE0_START      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE1_START      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE2_START      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ANTIFREEZE       = 3'd7;

	localparam logic ACTION_EVALUATE = 1'b0;
	localparam logic ACTION_WRITE    = 1'b1;

	typedef struct packed {
		logic [5:0]         pad;
		logic [5:0]         entry_setpoint;
		logic [2:0]         entry_step;
		logic [2:0]         entry_program;
		logic [2:0]         valid_mask;
		logic signed [10:0] temp_zone2;
		logic signed [10:0] temp_zone1;
		logic signed [10:0] temp_zone0;
		logic [4:0]         hour;
		logic [4:0]         day;
		logic [3:0]         month;
		logic [11:0]        time_hhmm;
	} item_t;

	typedef struct packed {
		logic [2:0] pad;
		logic [2:0] step_zone2;
		logic [2:0] step_zone1;
		logic [2:0] step_zone0;
		logic [2:0] zone_heat_mask;
		logic       heating_on;
	} result_t;

	typedef struct packed {
		logic load_item;
		logic prep;
		logic write_entry;
		logic start_zone;
		logic read;
		logic eval;
		logic next_step;
		logic finish_zone;
		logic next_zone;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_write;
		logic last_step;
		logic last_zone;
		logic out_free;
	} status_t;

endpackage

### rtl/core/zshd_ctrl.sv
// ----------------------------------------------------------------------------
// Zone schedule heating decision controller
// Sequences the table write or the per-zone schedule walk for one request.
// ----------------------------------------------------------------------------
module zshd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  zshd_pkg::status_t sts,
	output zshd_pkg::cmd_t    cmd
);
	import zshd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_ZONE = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (sts.is_write) begin
					cmd.write_entry = 1'b1;
					state_d         = S_DONE;
				end else begin
					cmd.start_zone = 1'b1;
					state_d        = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.last_step) begin
					state_d = S_ZONE;
				end else begin
					cmd.next_step = 1'b1;
					state_d       = S_READ;
				end
			end
			S_ZONE: begin
				cmd.finish_zone = 1'b1;
				if (sts.last_zone) begin
					state_d = S_DONE;
				end else begin
					cmd.next_zone  = 1'b1;
					cmd.start_zone = 1'b1;
					state_d        = S_READ;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/zshd_dp.sv
// ----------------------------------------------------------------------------
// Zone schedule heating decision datapath
// Holds the schedule memory, configuration registers, step search trackers,
// the heat decision and the result register.
// ----------------------------------------------------------------------------
module zshd_dp #(
	parameter int NUM_PROGRAMS  = zshd_pkg::NUM_PROGRAMS_DEF,
	parameter int STEPS_PER_DAY = zshd_pkg::STEPS_PER_DAY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  zshd_pkg::item_t                in_item,
	input  logic                           in_action,
	input  logic                           cfg_wr_en,
	input  logic [zshd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [zshd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  zshd_pkg::cmd_t                 cmd,
	output zshd_pkg::status_t              sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output zshd_pkg::result_t              out_result
);
	import zshd_pkg::*;

	localparam int DEPTH  = NUM_PROGRAMS * STEPS_PER_DAY;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int STEP_W = $clog2(STEPS_PER_DAY);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_PER_DAY - 1);

	logic [17:0] mem [DEPTH];
	logic [DEPTH-1:0] entry_valid_q;

	item_t item_q;
	logic  action_q;
	logic [NOW_W-1:0] now_q;

	logic [2:0]               active_mask_q;
	logic [2:0]               zone_prog_q [NUM_ZONES];
	logic [CFG_DATA_W-1:0]    start_after_q [NUM_ZONES];
	logic signed [10:0]       af_limit_q;

	logic [STEP_W-1:0] step_q;
	logic [ZONE_W-1:0] zone_q;
	logic broken_q, brk_zero_q, any_used_q, out_valid_q;
	logic [STEP_W-1:0] cand_step_q, lu_step_q;
	logic [5:0]        cand_sp_q, lu_sp_q, last_sp_q;
	logic [2:0]        heat_mask_q;
	logic [2:0]        steps_q [NUM_ZONES];
	result_t           res_q;

	logic [17:0] rd_word_s1;
	logic        rd_hit_s1;

	logic [2:0]             prog_sel;
	logic                   prog_ok;
	logic [ADDR_WIDE_W-1:0] rd_wide, wr_wide;
	logic [ADDR_W-1:0]      rd_idx, wr_idx;
	logic                   wr_ok;
	logic [11:0]            rd_time;
	logic [5:0]             rd_sp;
	logic                   hit;
	logic                   wrap;
	logic [STEP_W-1:0]      sel_step;
	logic [STEP_W+2:0]      sel_step_ext;
	logic [5:0]             sel_sp;
	logic [9:0]             want;
	logic signed [10:0]     temps [NUM_ZONES];
	logic signed [10:0]     temp_sel;
	logic                   valid_sel, act_sel, held, heat;
	logic [NOW_W-1:0]       now_d;

	assign prog_sel = zone_prog_q[zone_q];
	assign prog_ok  = 5'({2'b00, prog_sel}) < 5'(NUM_PROGRAMS);
	assign rd_wide  = ADDR_WIDE_W'(ADDR_WIDE_W'(prog_sel) * ADDR_WIDE_W'(STEPS_PER_DAY)
		+ ADDR_WIDE_W'(step_q));
	assign rd_idx   = rd_wide[ADDR_W-1:0];
	assign wr_wide  = ADDR_WIDE_W'(ADDR_WIDE_W'(item_q.entry_program)
		* ADDR_WIDE_W'(STEPS_PER_DAY) + ADDR_WIDE_W'(item_q.entry_step));
	assign wr_idx   = wr_wide[ADDR_W-1:0];
	assign wr_ok    = (5'({2'b00, item_q.entry_program}) < 5'(NUM_PROGRAMS))
		&& (5'({2'b00, item_q.entry_step}) < 5'(STEPS_PER_DAY));

	assign rd_time = rd_hit_s1 ? rd_word_s1[11:0] : 12'd0;
	assign rd_sp   = rd_hit_s1 ? rd_word_s1[17:12] : 6'd0;
	assign hit     = (rd_time > item_q.time_hhmm) || (rd_time == 12'd0);

	assign wrap     = broken_q && brk_zero_q;
	assign sel_step = wrap ? (any_used_q ? lu_step_q : LAST_STEP) : cand_step_q;
	assign sel_sp   = wrap ? (any_used_q ? lu_sp_q : last_sp_q) : cand_sp_q;
	assign sel_step_ext = (STEP_W + 3)'(sel_step);

	assign temps[0] = item_q.temp_zone0;
	assign temps[1] = item_q.temp_zone1;
	assign temps[2] = item_q.temp_zone2;
	assign temp_sel  = temps[zone_q];
	assign valid_sel = item_q.valid_mask[zone_q];
	assign act_sel   = active_mask_q[zone_q];
	assign want      = 10'({4'b0000, sel_sp} * 10'(SETPOINT_SCALE));
	assign held      = NOW_W'(start_after_q[zone_q]) > now_q;
	assign heat      = (($signed({2'b00, want}) > $signed({temp_sel[10], temp_sel}))
		&& act_sel && valid_sel && !held) || (valid_sel && (temp_sel < af_limit_q));

	assign now_d = NOW_W'(NOW_W'(item_q.month) * NOW_W'(MONTH_WEIGHT)
		+ NOW_W'(item_q.day) * NOW_W'(DAY_WEIGHT) + NOW_W'(item_q.hour));

	assign sts.is_write  = (action_q == ACTION_WRITE);
	assign sts.last_step = (step_q == LAST_STEP);
	assign sts.last_zone = (zone_q == LAST_ZONE);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_result = res_q;

	always_ff @(posedge clk) begin
		if (cmd.write_entry && wr_ok) begin
			mem[wr_idx] <= {item_q.entry_setpoint, item_q.time_hhmm};
		end
		if (cmd.read) begin
			rd_word_s1 <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			active_mask_q <= '0;
			zone_prog_q   <= '{default: '0};
			start_after_q <= '{default: '0};
			af_limit_q    <= 11'sd30;
			step_q        <= '0;
			zone_q        <= '0;
			broken_q      <= 1'b0;
			brk_zero_q    <= 1'b0;
			any_used_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			rd_hit_s1     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_ZONE_ACTIVE_MASK: active_mask_q    <= cfg_data[2:0];
					REG_ZONE0_PROGRAM:    zone_prog_q[0]   <= cfg_data[2:0];
					REG_ZONE1_PROGRAM:    zone_prog_q[1]   <= cfg_data[2:0];
					REG_ZONE2_PROGRAM:    zone_prog_q[2]   <= cfg_data[2:0];
					REG_ZONE0_START:      start_after_q[0] <= cfg_data;
					REG_ZONE1_START:      start_after_q[1] <= cfg_data;
					REG_ZONE2_START:      start_after_q[2] <= cfg_data;
					REG_ANTIFREEZE:       af_limit_q       <= $signed(cfg_data[10:0]);
					default: ;
				endcase
			end
			if (cmd.write_entry && wr_ok) begin
				entry_valid_q[wr_idx] <= 1'b1;
			end
			if (cmd.read) begin
				rd_hit_s1 <= entry_valid_q[rd_idx] && prog_ok;
			end
			if (cmd.prep) begin
				zone_q <= '0;
			end else if (cmd.next_zone) begin
				zone_q <= zone_q + 1'b1;
			end
			if (cmd.start_zone) begin
				step_q     <= '0;
				broken_q   <= 1'b0;
				brk_zero_q <= 1'b0;
				any_used_q <= 1'b0;
			end else if (cmd.eval) begin
				if (!broken_q && hit) begin
					broken_q   <= 1'b1;
					brk_zero_q <= (step_q == '0);
				end
				if (rd_time != 12'd0) begin
					any_used_q <= 1'b1;
				end
				if (cmd.next_step) begin
					step_q <= step_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q   <= in_item;
			action_q <= in_action;
		end
		if (cmd.prep) begin
			now_q       <= now_d;
			heat_mask_q <= '0;
			steps_q     <= '{default: '0};
		end
		if (cmd.eval) begin
			if (!broken_q && !hit) begin
				cand_step_q <= step_q;
				cand_sp_q   <= rd_sp;
			end
			if (rd_time != 12'd0) begin
				lu_step_q <= step_q;
				lu_sp_q   <= rd_sp;
			end
			if (step_q == LAST_STEP) begin
				last_sp_q <= rd_sp;
			end
		end
		if (cmd.finish_zone) begin
			heat_mask_q[zone_q] <= heat;
			steps_q[zone_q]     <= sel_step_ext[2:0];
		end
		if (cmd.load_out) begin
			res_q.pad            <= '0;
			res_q.heating_on     <= |heat_mask_q;
			res_q.zone_heat_mask <= heat_mask_q;
			res_q.step_zone0     <= steps_q[0];
			res_q.step_zone1     <= steps_q[1];
			res_q.step_zone2     <= steps_q[2];
		end
	end

endmodule

### rtl/core/zone_schedule_heating_decision_unit.sv
// ----------------------------------------------------------------------------
// Zone schedule heating decision unit
// Three-zone thermostat decision over a programmable day schedule.
// ----------------------------------------------------------------------------
// An evaluate request walks the three zones in turn and then loads the result;
// a table write stores its entry and loads a cleared result.
// The schedule memory has one read port, so each zone walks its steps one
// read and one compare at a time. One request is in flight at a time; the next
// is accepted in the cycle after the result moves to the output register, and the
// move waits while that register still holds a result not yet taken.
// Reset marks every schedule entry unwritten (zero) and resets control and config.
module zone_schedule_heating_decision_unit #(
	parameter int NUM_PROGRAMS  = zshd_pkg::NUM_PROGRAMS_DEF,
	parameter int STEPS_PER_DAY = zshd_pkg::STEPS_PER_DAY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// time_hhmm, month, day, hour, temp_zone0..2, valid_mask, entry_program,
	// entry_step, entry_setpoint, zero padding.
	input  logic [zshd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// action.
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// heating_on, zone_heat_mask, step_zone0, step_zone1, step_zone2, padding.
	output logic [zshd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_wr_en,
	input  logic [zshd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [zshd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import zshd_pkg::*;

	cmd_t    cmd;
	status_t sts;
	result_t result;

	zshd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	zshd_dp #(
		.NUM_PROGRAMS  (NUM_PROGRAMS),
		.STEPS_PER_DAY (STEPS_PER_DAY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (item_t'(s_axis_tdata)),
		.in_action  (s_axis_tuser),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = result;

	a_heat_or: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (|m_axis_tdata[3:1])))
		else $error("relay demand does not match the zone heat flags");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second request accepted while one is in progress");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result presented without a request in progress");

endmodule

### tb/sv/zone_schedule_heating_decision_checker.sv
// ----------------------------------------------------------------------------
// Zone schedule heating decision checker
// Watches the request, result and register write ports of the heating
// decision unit. It keeps its own schedule tables and register copies,
// predicts the decision for every accepted request and compares each result,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module zone_schedule_heating_decision_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [zshd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                             s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [zshd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_wr_en,
	input  logic [zshd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [zshd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatches,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import zshd_pkg::*;

	localparam int STEPS       = STEPS_PER_DAY_DEF;
	localparam int TABLE_DEPTH = NUM_PROGRAMS_DEF * STEPS;

	logic [11:0]           sched_time     [TABLE_DEPTH];
	logic [5:0]            sched_setpoint [TABLE_DEPTH];
	logic [NUM_ZONES-1:0]  zone_enable;
	logic [2:0]            zone_prog      [NUM_ZONES];
	logic [CFG_DATA_W-1:0] start_after    [NUM_ZONES];
	logic signed [10:0]    freeze_limit;
	result_t               decisions_due  [$];
	int                    failures = 0;
	int                    results_seen = 0;

	// The search stops at the first step that is unused or lies after now; the
	// step before it is active. Before the first step the last used step wraps.
	function automatic logic [2:0] find_active_step(input logic [2:0] prog,
			input logic [11:0] now_hhmm);
		int base;
		int i;
		int j;
		if (int'(prog) >= NUM_PROGRAMS_DEF) begin
			return 3'(STEPS - 1);
		end
		base = int'(prog) * STEPS;
		i = 0;
		while (i < STEPS && sched_time[base + i] != '0 && sched_time[base + i] <= now_hhmm)
			i++;
		if (i != 0) begin
			return 3'(i - 1);
		end
		j = STEPS - 1;
		while (j > 0 && sched_time[base + j] == '0)
			j--;
		return (sched_time[base + j] != '0) ? 3'(j) : 3'(STEPS - 1);
	endfunction

	function automatic result_t predict_heating(input item_t req);
		result_t              res;
		logic [2:0]           steps [NUM_ZONES];
		logic signed [10:0]   temps [NUM_ZONES];
		logic [NUM_ZONES-1:0] heat;
		int                   now_date;
		int                   want;
		int                   reading;
		int                   limit;
		now_date = int'(req.month) * MONTH_WEIGHT + int'(req.day) * DAY_WEIGHT
			+ int'(req.hour);
		temps[0] = req.temp_zone0;
		temps[1] = req.temp_zone1;
		temps[2] = req.temp_zone2;
		limit = freeze_limit;
		for (int z = 0; z < NUM_ZONES; z++) begin
			steps[z] = find_active_step(zone_prog[z], req.time_hhmm);
			if (int'(zone_prog[z]) < NUM_PROGRAMS_DEF) begin
				want = int'(sched_setpoint[int'(zone_prog[z]) * STEPS + int'(steps[z])])
					* SETPOINT_SCALE;
			end else begin
				want = 0;
			end
			reading = temps[z];
			heat[z] = (want > reading) && zone_enable[z] && req.valid_mask[z]
				&& !(int'(start_after[z]) > now_date);
			if (req.valid_mask[z] && reading < limit) begin
				heat[z] = 1'b1;
			end
		end
		res = '0;
		res.heating_on = |heat;
		res.zone_heat_mask = heat;
		res.step_zone0 = steps[0];
		res.step_zone1 = steps[1];
		res.step_zone2 = steps[2];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		item_t   req;
		result_t got;
		result_t due;
		result_t cleared;
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				sched_time[k] = '0;
				sched_setpoint[k] = '0;
			end
			zone_enable = '0;
			for (int z = 0; z < NUM_ZONES; z++) begin
				zone_prog[z] = '0;
				start_after[z] = '0;
			end
			freeze_limit = 11'sd30;
			decisions_due.delete();
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata);
				results_seen++;
				if (decisions_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("Result %0d arrived with no request waiting: %h",
							results_seen, m_axis_tdata);
				end else begin
					due = decisions_due.pop_front();
					if (got.heating_on !== due.heating_on
							|| got.zone_heat_mask !== due.zone_heat_mask
							|| got.step_zone0 !== due.step_zone0
							|| got.step_zone1 !== due.step_zone1
							|| got.step_zone2 !== due.step_zone2) begin
						failures++;
						if (failures <= 10)
							$display("Result %0d mismatch: expected heat %b mask %b ",
								results_seen, due.heating_on, due.zone_heat_mask,
								"steps %0d %0d %0d, ",
								due.step_zone0, due.step_zone1, due.step_zone2,
								"got heat %b mask %b steps %0d %0d %0d",
								got.heating_on, got.zone_heat_mask,
								got.step_zone0, got.step_zone1, got.step_zone2);
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ZONE_ACTIVE_MASK: zone_enable = cfg_data[2:0];
					REG_ZONE0_PROGRAM:    zone_prog[0] = cfg_data[2:0];
					REG_ZONE1_PROGRAM:    zone_prog[1] = cfg_data[2:0];
					REG_ZONE2_PROGRAM:    zone_prog[2] = cfg_data[2:0];
					REG_ZONE0_START:      start_after[0] = cfg_data;
					REG_ZONE1_START:      start_after[1] = cfg_data;
					REG_ZONE2_START:      start_after[2] = cfg_data;
					REG_ANTIFREEZE:       freeze_limit = cfg_data[10:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req = item_t'(s_axis_tdata);
				if (s_axis_tuser == ACTION_WRITE) begin
					if (int'(req.entry_program) < NUM_PROGRAMS_DEF
							&& int'(req.entry_step) < STEPS) begin
						sched_time[int'(req.entry_program) * STEPS + int'(req.entry_step)] =
							req.time_hhmm;
						sched_setpoint[int'(req.entry_program) * STEPS + int'(req.entry_step)] =
							req.entry_setpoint;
					end
					cleared = '0;
					decisions_due.push_back(cleared);
				end else begin
					decisions_due.push_back(predict_heating(req));
				end
			end
			mismatches <= failures;
			outstanding <= decisions_due.size();
		end
	end

endmodule

### tb/sv/zone_schedule_heating_decision_unit_tb.sv
// ----------------------------------------------------------------------------
// Zone schedule heating decision unit testbench
// Drives schedule writes and evaluate requests through the request stream,
// directed corner cases first and then random phases under several register
// settings, with bursty requests and a stalling result receiver. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module zone_schedule_heating_decision_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import zshd_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int STEPS           = STEPS_PER_DAY_DEF;

	typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_STALL} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     mismatches;
	int                     outstanding;
	int                     cycles = 0;
	int                     burst_left = 0;
	rx_mode_t               rx_mode = RX_STREAM;
	int                     rx_left = 0;

	zone_schedule_heating_decision_unit DUT (.*);

	zone_schedule_heating_decision_checker decision_check (.*);

	always #10ns clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[zone_schedule_heating_decision_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(20, 300);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_STREAM: m_axis_tready <= 1'b1;
			RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
			default:   m_axis_tready <= (rx_left % 40 == 0);
		endcase
	end

	function automatic item_t noise_item();
		item_t r;
		r = '0;
		r.time_hhmm = 12'($urandom);
		r.month = 4'($urandom);
		r.day = 5'($urandom);
		r.hour = 5'($urandom);
		r.temp_zone0 = 11'($urandom);
		r.temp_zone1 = 11'($urandom);
		r.temp_zone2 = 11'($urandom);
		r.valid_mask = 3'($urandom);
		r.entry_program = 3'($urandom);
		r.entry_step = 3'($urandom);
		r.entry_setpoint = 6'($urandom);
		return r;
	endfunction

	function automatic item_t entry_item(input logic [2:0] prog, input logic [2:0] step,
			input logic [11:0] stamp, input logic [5:0] setpoint);
		item_t r;
		r = noise_item();
		r.entry_program = prog;
		r.entry_step = step;
		r.time_hhmm = stamp;
		r.entry_setpoint = setpoint;
		return r;
	endfunction

	function automatic item_t eval_item(input logic [11:0] stamp, input logic [3:0] month,
			input logic [4:0] day, input logic [4:0] hour, input logic signed [10:0] t0,
			input logic signed [10:0] t1, input logic signed [10:0] t2,
			input logic [2:0] valid);
		item_t r;
		r = noise_item();
		r.time_hhmm = stamp;
		r.month = month;
		r.day = day;
		r.hour = hour;
		r.temp_zone0 = t0;
		r.temp_zone1 = t1;
		r.temp_zone2 = t2;
		r.valid_mask = valid;
		return r;
	endfunction

	function automatic logic [11:0] pick_hhmm();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return 12'($urandom);
		return 12'($urandom_range(0, 23) * 100 + $urandom_range(0, 59));
	endfunction

	function automatic logic signed [10:0] pick_temp();
		return 11'(int'($urandom_range(0, 420)) - 60);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_date();
		return CFG_DATA_W'($urandom_range(1, 12) * MONTH_WEIGHT
			+ $urandom_range(1, 31) * DAY_WEIGHT + $urandom_range(0, 23));
	endfunction

	task automatic send_request(input item_t req, input logic act);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tdata <= req;
		s_axis_tuser <= act;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Holds requests back until every result has come and the unit is idle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [2:0] enable_mask, input logic [2:0] p0,
			input logic [2:0] p1, input logic [2:0] p2, input logic [CFG_DATA_W-1:0] s0,
			input logic [CFG_DATA_W-1:0] s1, input logic [CFG_DATA_W-1:0] s2,
			input logic signed [10:0] limit);
		write_reg(REG_ZONE_ACTIVE_MASK, CFG_DATA_W'(enable_mask));
		write_reg(REG_ZONE0_PROGRAM, CFG_DATA_W'(p0));
		write_reg(REG_ZONE1_PROGRAM, CFG_DATA_W'(p1));
		write_reg(REG_ZONE2_PROGRAM, CFG_DATA_W'(p2));
		write_reg(REG_ZONE0_START, s0);
		write_reg(REG_ZONE1_START, s1);
		write_reg(REG_ZONE2_START, s2);
		write_reg(REG_ANTIFREEZE, {{(CFG_DATA_W - 11){1'b0}}, limit});
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Loads a whole program with rising step times; steps past the used count
	// are left unused.
	task automatic write_schedule(input logic [2:0] prog);
		int          used;
		int          mins;
		logic [11:0] stamp;
		used = $urandom_range(0, STEPS);
		mins = 0;
		for (int s = 0; s < STEPS; s++) begin
			mins += $urandom_range(1, 300);
			if (s >= used || mins > 1439)
				stamp = '0;
			else
				stamp = 12'((mins / 60) * 100 + mins % 60);
			send_request(entry_item(prog, 3'(s), stamp, 6'($urandom_range(5, 30))),
				ACTION_WRITE);
		end
	endtask

	task automatic send_random_request();
		item_t req;
		logic  act;
		req = noise_item();
		act = ($urandom_range(0, 3) == 0) ? ACTION_WRITE : ACTION_EVALUATE;
		if (act == ACTION_WRITE) begin
			req.entry_step = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			req.time_hhmm = pick_hhmm();
			if ($urandom_range(0, 3) != 0)
				req.entry_setpoint = 6'($urandom_range(0, 40));
		end else if ($urandom_range(0, 7) != 0) begin
			req.time_hhmm = pick_hhmm();
			req.month = 4'($urandom_range(1, 12));
			req.day = 5'($urandom_range(1, 31));
			req.hour = 5'($urandom_range(0, 23));
			req.temp_zone0 = pick_temp();
			req.temp_zone1 = pick_temp();
			req.temp_zone2 = pick_temp();
		end
		send_request(req, act);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACTION_EVALUATE;
		cfg_wr_en = 1'b0;
		cfg_index = REG_ZONE_ACTIVE_MASK;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(3'b111, 3'd0, 3'd1, 3'd7, 17'd0, 17'd0, 17'd123123, 11'sd30);
		// Empty tables: every zone falls back to the last step with no setpoint.
		send_request(eval_item(12'd1230, 4'd6, 5'd15, 5'd12, 11'sd0, 11'sd100, -11'sd5,
			3'b111), ACTION_EVALUATE);
		send_request(entry_item(3'd0, 3'd0, 12'd600, 6'd21), ACTION_WRITE);
		send_request(entry_item(3'd0, 3'd1, 12'd800, 6'd17), ACTION_WRITE);
		send_request(entry_item(3'd0, 3'd2, 12'd1700, 6'd22), ACTION_WRITE);
		send_request(entry_item(3'd0, 3'd3, 12'd2200, 6'd16), ACTION_WRITE);
		send_request(entry_item(3'd1, 3'd0, 12'd100, 6'd40), ACTION_WRITE);
		send_request(entry_item(3'd1, 3'd1, 12'd400, 6'd0), ACTION_WRITE);
		send_request(entry_item(3'd1, 3'd2, 12'd800, 6'd63), ACTION_WRITE);
		send_request(entry_item(3'd1, 3'd3, 12'd1200, 6'd5), ACTION_WRITE);
		send_request(entry_item(3'd1, 3'd4, 12'd1800, 6'd30), ACTION_WRITE);
		send_request(entry_item(3'd1, 3'd5, 12'd2359, 6'd20), ACTION_WRITE);
		// Step indexes beyond the program must leave the table untouched.
		send_request(entry_item(3'd1, 3'd6, 12'd50, 6'd63), ACTION_WRITE);
		send_request(entry_item(3'd1, 3'd7, 12'd1, 6'd1), ACTION_WRITE);
		// An unused first step ends the search at once and wraps to the last used.
		send_request(entry_item(3'd7, 3'd0, 12'd0, 6'd33), ACTION_WRITE);
		send_request(entry_item(3'd7, 3'd1, 12'd900, 6'd25), ACTION_WRITE);
		send_request(eval_item(12'd0, 4'd1, 5'd1, 5'd0, 11'h400, 11'sd1023, -11'sd400,
			3'b111), ACTION_EVALUATE);
		send_request(eval_item(12'd600, 4'd3, 5'd10, 5'd6, 11'sd209, 11'sd210, 11'sd800,
			3'b111), ACTION_EVALUATE);
		send_request(eval_item(12'd2359, 4'd12, 5'd31, 5'd22, 11'sd150, 11'sd199, 11'sd100,
			3'b111), ACTION_EVALUATE);
		send_request(eval_item(12'd4095, 4'd12, 5'd31, 5'd23, 11'sd150, 11'sd199, 11'sd100,
			3'b111), ACTION_EVALUATE);
		send_request(eval_item(12'd1000, 4'd15, 5'd31, 5'd31, 11'sd29, 11'sd29, 11'sd29,
			3'b000), ACTION_EVALUATE);
		send_request(eval_item(12'd1000, 4'd15, 5'd31, 5'd31, 11'sd29, 11'sd30, 11'sd31,
			3'b101), ACTION_EVALUATE);
		send_request(eval_item(12'd1759, 4'd0, 5'd0, 5'd0, 11'sd219, 11'sd50, 11'sd300,
			3'b011), ACTION_EVALUATE);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			case (phase)
				0: set_config(3'b111, 3'($urandom), 3'($urandom), 3'($urandom),
					17'd0, 17'd0, 17'd0, -11'sd400);
				1: set_config(3'b000, 3'($urandom), 3'($urandom), 3'($urandom),
					17'd131071, 17'd131071, 17'd131071, 11'sd800);
				2: set_config(3'b111, 3'($urandom), 3'($urandom), 3'($urandom),
					17'd123123, 17'd0, random_date(), 11'sd1023);
				3: set_config(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
					random_date(), 17'd131071, random_date(), 11'h400);
				default: set_config(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
					random_date(), random_date(), 17'($urandom),
					11'(int'($urandom_range(0, 1200)) - 400));
			endcase
			repeat (3) write_schedule(3'($urandom));
			repeat (ITEMS_PER_PHASE) send_random_request();
		end

		settle();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("[zone_schedule_heating_decision_unit] OK");
		end else begin
			$display("[zone_schedule_heating_decision_unit] ERROR");
		end
		$finish;
	end

endmodule
